// ----- sv/nkw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nkw_pkg
// Types, register codes and the note frequency table shared by the note to
// key register writer.
// ----------------------------------------------------------------------------
package nkw_pkg;

  localparam int NOTE_W      = 7;
  localparam int NOTE_RANGE  = 1 << NOTE_W;
  localparam int FTONE_W     = 14;
  localparam int MO_W        = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CH_W        = 3;
  localparam int Semitones   = 12;

  localparam logic REQ_NOTE_ON  = 1'b0;
  localparam logic REQ_NOTE_OFF = 1'b1;

  localparam logic [7:0] ADDR_OP  = 8'h30;
  localparam logic [7:0] ADDR_FHI = 8'hA4;
  localparam logic [7:0] ADDR_FLO = 8'hA0;
  localparam logic [7:0] ADDR_KEY = 8'h28;
  localparam logic [7:0] KEY_ON   = 8'hF0;
  localparam logic [7:0] DT_MASK  = 8'hF0;
  localparam logic [3:0] MUL_MAX  = 4'hF;

  localparam logic [63:0] THRESH_BLOCK = 64'd67092480;
  localparam logic [63:0] THRESH_MUL   = 64'd133480448;
  localparam logic [63:0] ROUND_HALF   = 64'h8000;
  localparam int unsigned BLOCK_MAX    = 7;

  localparam logic [31:0] SEMITONE_Q16 [Semitones] = '{
    32'd21095093, 32'd22349472, 32'd23678441, 32'd25086434,
    32'd26578151, 32'd28158570, 32'd29832966, 32'd31606927,
    32'd33486372, 32'd35477576, 32'd37587182, 32'd39822233
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL = 3'd0,
    CFG_OP0     = 3'd1,
    CFG_OP1     = 3'd2,
    CFG_OP2     = 3'd3,
    CFG_OP3     = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    STEP_OP0, STEP_OP1, STEP_OP2, STEP_OP3, STEP_FHI, STEP_FLO, STEP_KEY
  } step_t;

  typedef struct packed {
    logic [FTONE_W-1:0] ftone;
    logic [MO_W-1:0]    mo;
  } rom_entry_t;

  typedef struct packed {
    logic               is_off;
    logic [FTONE_W-1:0] ftone;
    logic [MO_W-1:0]    mo;
  } q_entry_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [3:0][7:0]  op_dm;
  } cfg_t;

  // Block, F-number and multiplier offset of one note, evaluated at elaboration.
  function automatic rom_entry_t note_entry(input int unsigned n);
    rom_entry_t  e;
    logic [63:0] base;
    logic [63:0] val;
    int unsigned shift;
    int unsigned block;
    int unsigned mo;
    int          i;
    base  = 64'(SEMITONE_Q16[n % Semitones]);
    shift = n / Semitones;
    block = 0;
    mo    = 0;
    for (i = 0; i < NOTE_RANGE / Semitones + 1; i++) begin
      if (shift > 0 && (base << shift) >= THRESH_BLOCK && block < BLOCK_MAX) begin
        shift--;
        block++;
      end
    end
    for (i = 0; i < NOTE_RANGE / Semitones + 1; i++) begin
      if (shift > 0 && (base << shift) >= THRESH_MUL) begin
        shift--;
        mo++;
      end
    end
    val     = ((base << shift) + ROUND_HALF) >> 16;
    e.ftone = FTONE_W'((64'(block) << 11) + val);
    e.mo    = MO_W'(mo);
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- sv/fm_note_key_register_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fm_note_key_register_writer
// Note on / note off requests in, FM chip register writes out.
// The first write passes through the queue, the write sequencer and the
// registered output stage. A note on gives seven writes, a note off one;
// the single write sequencer sends them in turn, holding while m_tready is low.
// A two-entry queue takes further requests while writes are in progress.
// Reset (rst, synchronous): queue and output empty, configuration and pointers to 0.
// ----------------------------------------------------------------------------
module fm_note_key_register_writer #(
  parameter int NOTE_COUNT = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nkw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [6:0] note
  input  wire logic                            s_tuser,   // [0] req_type
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [15:0]                          m_tdata,   // [7:0] reg_addr, [15:8] reg_data
  output logic                                 m_tuser,   // [0] reg_port
  output logic                                 m_tlast
);
  import nkw_pkg::*;

  cfg_t     cfg;
  q_entry_t entry;
  q_entry_t head;
  logic     push;
  logic     q_full;
  logic     pop;
  logic     head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL: cfg.channel  <= cfg_data[CH_W-1:0];
        CFG_OP0:     cfg.op_dm[0] <= cfg_data;
        CFG_OP1:     cfg.op_dm[1] <= cfg_data;
        CFG_OP2:     cfg.op_dm[2] <= cfg_data;
        CFG_OP3:     cfg.op_dm[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  nkw_front #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .push    (push),
    .entry   (entry),
    .q_full  (q_full)
  );

  nkw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  nkw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ----- sv/nkw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nkw_front
// Accepts requests, saturates the note and looks up block, F-number and
// multiplier offset, then queues the classified request.
// ----------------------------------------------------------------------------
module nkw_front #(
  parameter int NOTE_COUNT = 128
) (
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [6:0] note
  input  wire logic              s_tuser,   // [0] req_type
  output logic                   push,
  output nkw_pkg::q_entry_t      entry,
  input  wire logic              q_full
);
  import nkw_pkg::*;

  rom_entry_t        rom [NOTE_RANGE];
  logic [NOTE_W-1:0] note_sat;

  for (genvar g = 0; g < NOTE_RANGE; g++) begin : g_rom
    assign rom[g] = note_entry(g);
  end

  always_comb begin
    if ({2'b00, s_tdata[NOTE_W-1:0]} > 9'(NOTE_COUNT - 1)) begin
      note_sat = NOTE_W'(NOTE_COUNT - 1);
    end else begin
      note_sat = s_tdata[NOTE_W-1:0];
    end
  end

  assign s_tready     = !q_full;
  assign push         = s_tvalid && !q_full;
  assign entry.is_off = (s_tuser == REQ_NOTE_OFF);
  assign entry.ftone  = rom[note_sat].ftone;
  assign entry.mo     = rom[note_sat].mo;

endmodule
`default_nettype wire

// ----- sv/nkw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nkw_queue
// Two-entry queue between the request front end and the write sequencer.
// ----------------------------------------------------------------------------
module nkw_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire nkw_pkg::q_entry_t entry,
  output logic                   full,
  input  wire logic              pop,
  output nkw_pkg::q_entry_t      head,
  output logic                   head_valid
);
  import nkw_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  q_entry_t          mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full       = (count == (PtrW + 1)'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

endmodule
`default_nettype wire

// ----- sv/nkw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nkw_back
// Write sequencer: turns a queued request into its register writes, one per
// cycle while m_tready does not stall the output, through a registered output stage.
// ----------------------------------------------------------------------------
module nkw_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nkw_pkg::cfg_t     cfg,
  input  wire nkw_pkg::q_entry_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,   // [7:0] reg_addr, [15:8] reg_data
  output logic                   m_tuser,   // [0] reg_port
  output logic                   m_tlast
);
  import nkw_pkg::*;

  q_entry_t          cur;
  logic [MO_W-1:0]   mo;
  logic [MO_W-1:0]   mo_next;
  step_t             step;
  step_t             step_next;
  logic              busy;
  logic              advance;
  logic              emit;
  logic              is_last;

  logic [CH_W-1:0]   ch;
  logic              port;
  logic [1:0]        slot;
  logic [7:0]        key;
  logic [7:0]        op_reg;
  logic [4:0]        mul_sum;
  logic [7:0]        w_addr;
  logic [7:0]        w_data;
  logic              w_port;

  // Channel six and seven fold back to zero and one.
  always_comb begin
    ch   = (cfg.channel >= 3'd6) ? cfg.channel - 3'd6 : cfg.channel;
    port = (ch >= 3'd3);
    slot = port ? 2'(ch - 3'd3) : 2'(ch);
    key  = port ? 8'(ch) + 8'd1 : 8'(ch);
  end

  always_comb begin
    op_reg    = cfg.op_dm[step[1:0]];
    mul_sum   = {1'b0, op_reg[3:0]} + 5'(mo);
    mo_next   = mo;
    w_port    = port;
    w_addr    = ADDR_KEY;
    w_data    = KEY_ON + key;
    step_next = step_t'(step + 3'd1);
    unique case (step)
      STEP_OP0, STEP_OP1, STEP_OP2, STEP_OP3: begin
        w_addr = ADDR_OP + {4'b0000, step[1:0], 2'b00} + {6'b000000, slot};
        w_data = op_reg;
        if (mo != '0) begin
          // clamp at the top multiplier; later operators go out unchanged
          if (mul_sum > {1'b0, MUL_MAX}) begin
            w_data  = (op_reg & DT_MASK) | {4'h0, MUL_MAX};
            mo_next = '0;
          end else begin
            w_data = (op_reg & DT_MASK) | {4'h0, mul_sum[3:0]};
          end
        end
      end
      STEP_FHI: begin
        w_addr = ADDR_FHI + {6'b000000, slot};
        w_data = 8'(cur.ftone >> 8);
      end
      STEP_FLO: begin
        w_addr = ADDR_FLO + {6'b000000, slot};
        w_data = cur.ftone[7:0];
      end
      STEP_KEY: begin
        w_port = 1'b0;
      end
      default: begin
        w_port = 1'b0;
      end
    endcase
    if (cur.is_off) begin
      w_port = 1'b0;
      w_addr = ADDR_KEY;
      w_data = key;
    end
  end

  assign is_last = cur.is_off || (step == STEP_KEY);
  assign advance = !m_tvalid || m_tready;
  assign emit    = busy && advance;
  assign pop     = head_valid && (!busy || (emit && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= STEP_OP0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= STEP_OP0;
      end else if (emit) begin
        if (is_last) begin
          busy <= 1'b0;
        end
        step <= step_next;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      mo  <= head.mo;
    end else if (emit) begin
      mo <= mo_next;
    end
    if (emit) begin
      m_tdata <= {w_data, w_addr};
      m_tuser <= w_port;
      m_tlast <= is_last;
    end
  end

`ifndef SYNTH
  a_last_is_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[7:0] == ADDR_KEY) && !m_tuser)
    else $error("final write of a request is not a key write on port 0");

  a_busy_mid_request: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> busy)
    else $error("sequencer idle while a request is half written");

  a_off_single: assert property (@(posedge clk) disable iff (rst)
    emit && cur.is_off |-> is_last && (step == STEP_OP0))
    else $error("note off produced more than one write");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= STEP_KEY)
    else $error("write step out of range");
`endif

endmodule
`default_nettype wire
